// ===== design/connection_heartbeat_table_defines.svh =====
// Assertion macros used by the connection heartbeat table back end
`ifndef CONNECTION_HEARTBEAT_TABLE_DEFINES_SVH
`define CONNECTION_HEARTBEAT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CHT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

`define CHT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define CHT_ASSERT_ALWAYS(label, clk, rst, cond)
`define CHT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/cht_pkg.sv =====
// Types and constants of the connection heartbeat table
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

   localparam int SLOTS_DEFAULT = 32;

   localparam int TIME_W    = 48;
   localparam int WALL_W    = 32;
   localparam int ID_W      = 6;
   localparam int TOTAL_W   = 7;
   localparam int BEAT_W    = 8;
   localparam int KIND_W    = 2;
   localparam int REQ_W     = 2;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEEDUP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd2;

   localparam logic [CSR_W-1:0]  TIMEOUT_RESET = 32'd30000;
   localparam logic [CSR_W-1:0]  SPEEDUP_RESET = 32'd1000;
   localparam logic [BEAT_W-1:0] LIMIT_RESET   = 8'd5;

   // request codes on the input word
   localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_BEAT = 2'd2;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd3;

   // internal operations after classification
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd1;
   localparam logic [OP_W-1:0] OP_BEAT = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK = 3'd3;
   localparam logic [OP_W-1:0] OP_ACK  = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] EV_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] EV_LOGOUT = 2'd1;
   localparam logic [KIND_W-1:0] EV_PUSH   = 2'd2;

   localparam logic [TIME_W-1:0] FIRST_INTERVAL = 48'd10000;
   localparam logic [TIME_W-1:0] INTERVAL_MAX   = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] INTERVAL_SAT   = INTERVAL_MAX / 48'd10;

   typedef struct packed {
      logic [CSR_W-1:0]  timeout_ms;
      logic [CSR_W-1:0]  speedup_ms;
      logic [BEAT_W-1:0] speedup_limit;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   slot_id;
      logic [TIME_W-1:0] now_ms;
      logic [WALL_W-1:0] wall_seconds;
   } cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] beat_stamp;
      logic [TIME_W-1:0] push_stamp;
      logic [TIME_W-1:0] push_interval;
      logic [BEAT_W-1:0] fast_count;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/cht_front.sv =====
// Front end: classifies request words and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module cht_front #(
   parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [cht_pkg::REQ_W-1:0]    req_type,
   input  wire  [cht_pkg::ID_W-1:0]     req_conn_id,
   input  wire  [cht_pkg::TIME_W-1:0]   req_now_ms,
   input  wire  [cht_pkg::WALL_W-1:0]   req_wall_seconds,
   output logic                         cmd_valid,
   input  wire                          cmd_pop,
   output cht_pkg::cmd_type             cmd_head
);
   import cht_pkg::*;

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               in_range;
   cmd_type            decoded;

   always_comb begin
      in_range             = ({1'b0, req_conn_id} < (ID_W + 1)'(SLOTS));
      decoded.slot_id      = req_conn_id;
      decoded.now_ms       = req_now_ms;
      decoded.wall_seconds = req_wall_seconds;
      unique case (req_type)
         REQ_ADD:  decoded.op = in_range ? OP_ADD : OP_ACK;
         REQ_DEL:  decoded.op = in_range ? OP_DEL : OP_ACK;
         REQ_BEAT: decoded.op = in_range ? OP_BEAT : OP_ACK;
         REQ_TICK: decoded.op = OP_TICK;
         default:  decoded.op = OP_ACK;
      endcase
   end

   always_comb begin
      req_ready = (count_ff < QCNT_W'(QUEUE_DEPTH));
      push      = req_valid && req_ready;
      cmd_valid = (count_ff != '0);
      cmd_head  = q_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/cht_back.sv =====
// Back end: slot table, request execution, tick sweep and result register
`timescale 1ns / 1ps
`default_nettype none
`include "connection_heartbeat_table_defines.svh"
module cht_back #(
   parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  cht_pkg::cfg_type             cfg,
   input  wire                          cmd_valid,
   output logic                         cmd_pop,
   input  cht_pkg::cmd_type             cmd_head,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [cht_pkg::KIND_W-1:0]   rsp_event_kind,
   output logic [cht_pkg::ID_W-1:0]     rsp_event_slot,
   output logic [cht_pkg::TIME_W-1:0]   rsp_push_time_ms,
   output logic [cht_pkg::WALL_W-1:0]   rsp_push_wall_seconds,
   output logic [cht_pkg::TOTAL_W-1:0]  rsp_active_count,
   output logic                         rsp_last_of_run
);
   import cht_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EXEC      = 3'd1;
   localparam logic [2:0] S_TICK_RD   = 3'd2;
   localparam logic [2:0] S_TICK_EVAL = 3'd3;
   localparam logic [2:0] S_TICK_END  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SLOTS-1:0]    slot_valid_ff, slot_valid_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   entry_type           mem [SLOTS];
   entry_type           rd_data_ff;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   entry_type           wr_data;
   logic [SLOT_W-1:0]   cur_addr;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     slot_ff, slot_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [WALL_W-1:0]   wall_ff, wall_in;
   logic [TOTAL_W-1:0]  count_ff, count_in;
   logic                last_ff, last_in;
   logic                out_load;
   logic                out_free;

   logic [TIME_W:0]     beat_gap;
   logic [TIME_W:0]     push_gap;
   logic                timed_out;
   logic                too_fast;
   logic                push_due;
   logic [TIME_W-1:0]   interval_next;
   logic [BEAT_W-1:0]   beat_inc;
   logic                cur_valid;
   logic                need_emit;

   // slot evaluation on the registered table read
   always_comb begin
      cur_addr      = (state_ff == S_EXEC) ? cmd_ff.slot_id[SLOT_W-1:0] : idx_ff;
      cur_valid     = slot_valid_ff[cur_addr];
      beat_gap      = {1'b0, cmd_ff.now_ms} - {1'b0, rd_data_ff.beat_stamp};
      push_gap      = {1'b0, cmd_ff.now_ms} - {1'b0, rd_data_ff.push_stamp};
      timed_out     = !beat_gap[TIME_W] &&
                      (beat_gap[TIME_W-1:0] > TIME_W'(cfg.timeout_ms));
      too_fast      = beat_gap[TIME_W] ||
                      (beat_gap[TIME_W-1:0] <= TIME_W'(cfg.speedup_ms));
      push_due      = !push_gap[TIME_W] &&
                      (push_gap[TIME_W-1:0] > rd_data_ff.push_interval);
      interval_next = (rd_data_ff.push_interval > INTERVAL_SAT) ? INTERVAL_MAX :
                      (rd_data_ff.push_interval << 3) + (rd_data_ff.push_interval << 1);
      beat_inc      = (rd_data_ff.fast_count == {BEAT_W{1'b1}}) ?
                      rd_data_ff.fast_count : rd_data_ff.fast_count + 1'b1;
      need_emit     = cur_valid && (timed_out || push_due);
      out_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      slot_valid_in = slot_valid_ff;
      total_in      = total_ff;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data_ff;
      out_load      = 1'b0;
      kind_in       = EV_ACK;
      slot_in       = '0;
      time_in       = '0;
      wall_in       = '0;
      last_in       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               rd_en   = 1'b1;
               if (cmd_head.op == OP_TICK) begin
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = S_TICK_EVAL;
               end else begin
                  rd_addr  = cmd_head.slot_id[SLOT_W-1:0];
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               out_load = 1'b1;
               slot_in  = cmd_ff.slot_id;
               last_in  = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff.op)
                  OP_ADD: begin
                     if (!cur_valid) begin
                        slot_valid_in[cur_addr] = 1'b1;
                        total_in                = total_ff + 1'b1;
                        wr_en                   = 1'b1;
                        wr_data.beat_stamp      = cmd_ff.now_ms;
                        wr_data.push_stamp      = cmd_ff.now_ms;
                        wr_data.push_interval   = FIRST_INTERVAL;
                        wr_data.fast_count      = '0;
                     end
                  end
                  OP_DEL: begin
                     if (cur_valid) begin
                        slot_valid_in[cur_addr] = 1'b0;
                        total_in                = total_ff - 1'b1;
                     end
                  end
                  OP_BEAT: begin
                     if (cur_valid) begin
                        wr_en = 1'b1;
                        if (too_fast) begin
                           wr_data.fast_count = beat_inc;
                           if (beat_inc >= cfg.speedup_limit) begin
                              kind_in = EV_LOGOUT;
                           end else begin
                              wr_data.beat_stamp = cmd_ff.now_ms;
                           end
                        end else begin
                           wr_data.beat_stamp = cmd_ff.now_ms;
                           wr_data.fast_count = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TICK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_TICK_EVAL;
         end
         S_TICK_EVAL: begin
            if (!need_emit || out_free) begin
               if (need_emit) begin
                  out_load = 1'b1;
                  slot_in  = ID_W'(idx_ff);
                  if (timed_out) begin
                     kind_in = EV_LOGOUT;
                  end else begin
                     kind_in               = EV_PUSH;
                     time_in               = cmd_ff.now_ms;
                     wall_in               = cmd_ff.wall_seconds;
                     wr_en                 = 1'b1;
                     wr_data.push_stamp    = cmd_ff.now_ms;
                     wr_data.push_interval = interval_next;
                  end
               end
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = S_TICK_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TICK_RD;
               end
            end
         end
         S_TICK_END: begin
            if (out_free) begin
               out_load = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      count_in     = total_in;
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      if (out_load) begin
         kind_ff  <= kind_in;
         slot_ff  <= slot_in;
         time_ff  <= time_in;
         wall_ff  <= wall_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_kind        = kind_ff;
   assign rsp_event_slot        = slot_ff;
   assign rsp_push_time_ms      = time_ff;
   assign rsp_push_wall_seconds = wall_ff;
   assign rsp_active_count      = count_ff;
   assign rsp_last_of_run       = last_ff;

   `CHT_ASSERT_ALWAYS(a_total_matches_valid, clock, reset, total_ff == TOTAL_W'($countones(slot_valid_ff)))
   `CHT_ASSERT_IMPLY(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !out_load)
   `CHT_ASSERT_NEXT(a_last_returns_idle, clock, reset, out_load && last_in, state_ff == S_IDLE)
   `CHT_ASSERT_IMPLY(a_pop_needs_word, clock, reset, cmd_pop, cmd_valid && state_ff == S_IDLE)

endmodule
`default_nettype wire

// ===== design/connection_heartbeat_table.sv =====
// Top level of the connection heartbeat table: config registers, front and back ends
// Add, delete and heartbeat words take a table read, then update and result, in the
// back end. A tick reads, then checks each slot in turn (the sweep walks the table in
// index order) and closes with a final word. A result waits in the result register
// until rsp_ready takes it, and the back end holds a new result until then. A two-word
// queue lets requests arrive while the back end works, and a result register lets the
// next word start while a result waits on rsp_ready.
`timescale 1ns / 1ps
`default_nettype none
module connection_heartbeat_table #(
   parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [cht_pkg::REQ_W-1:0]      req_type,
   input  wire  [cht_pkg::ID_W-1:0]       req_conn_id,
   input  wire  [cht_pkg::TIME_W-1:0]     req_now_ms,
   input  wire  [cht_pkg::WALL_W-1:0]     req_wall_seconds,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [cht_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [cht_pkg::ID_W-1:0]       rsp_event_slot,
   output logic [cht_pkg::TIME_W-1:0]     rsp_push_time_ms,
   output logic [cht_pkg::WALL_W-1:0]     rsp_push_wall_seconds,
   output logic [cht_pkg::TOTAL_W-1:0]    rsp_active_count,
   output logic                           rsp_last_of_run,
   input  wire                            csr_we,
   input  wire  [cht_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [cht_pkg::CSR_W-1:0]      csr_wdata
);
   import cht_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cmd_valid;
   logic     cmd_pop;
   cmd_type  cmd_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT: cfg_in.timeout_ms    = csr_wdata;
            CSR_SPEEDUP: cfg_in.speedup_ms    = csr_wdata;
            CSR_LIMIT:   cfg_in.speedup_limit = csr_wdata[BEAT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms    <= TIMEOUT_RESET;
         cfg_ff.speedup_ms    <= SPEEDUP_RESET;
         cfg_ff.speedup_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cht_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_conn_id      (req_conn_id),
      .req_now_ms       (req_now_ms),
      .req_wall_seconds (req_wall_seconds),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_head         (cmd_head)
   );

   cht_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .cmd_valid             (cmd_valid),
      .cmd_pop               (cmd_pop),
      .cmd_head              (cmd_head),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_event_slot        (rsp_event_slot),
      .rsp_push_time_ms      (rsp_push_time_ms),
      .rsp_push_wall_seconds (rsp_push_wall_seconds),
      .rsp_active_count      (rsp_active_count),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// ===== tb/connection_heartbeat_table_tb.sv =====
// Self-checking testbench for the connection heartbeat table: directed rows, directed sequences, then random words
`timescale 1ns / 1ps
module connection_heartbeat_table_tb;
   import cht_pkg::*;

   localparam int SLOT_COUNT = SLOTS_DEFAULT;

   typedef struct packed {
      logic [REQ_W-1:0]  op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] now;
      logic [WALL_W-1:0] wall;
   } table_req_t;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    slot;
      logic [TIME_W-1:0]  ptime;
      logic [WALL_W-1:0]  pwall;
      logic [TOTAL_W-1:0] count;
      logic               last;
   } table_evt_t;

   typedef struct packed {
      table_req_t r;
      logic       typed;
      table_evt_t want;
   } plan_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [REQ_W-1:0]     req_type = REQ_ADD;
   logic [ID_W-1:0]      req_conn_id = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic [WALL_W-1:0]    req_wall_seconds = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [KIND_W-1:0]    rsp_event_kind;
   logic [ID_W-1:0]      rsp_event_slot;
   logic [TIME_W-1:0]    rsp_push_time_ms;
   logic [WALL_W-1:0]    rsp_push_wall_seconds;
   logic [TOTAL_W-1:0]   rsp_active_count;
   logic                 rsp_last_of_run;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TIMEOUT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   connection_heartbeat_table DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_conn_id           (req_conn_id),
      .req_now_ms            (req_now_ms),
      .req_wall_seconds      (req_wall_seconds),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_event_slot        (rsp_event_slot),
      .rsp_push_time_ms      (rsp_push_time_ms),
      .rsp_push_wall_seconds (rsp_push_wall_seconds),
      .rsp_active_count      (rsp_active_count),
      .rsp_last_of_run       (rsp_last_of_run),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the limits and the slot table
   logic [CSR_W-1:0]   cfg_timeout = TIMEOUT_RESET;
   logic [CSR_W-1:0]   cfg_speedup = SPEEDUP_RESET;
   logic [BEAT_W-1:0]  cfg_limit   = LIMIT_RESET;
   bit                 slot_live  [SLOT_COUNT];
   logic [TIME_W-1:0]  beat_at    [SLOT_COUNT];
   logic [TIME_W-1:0]  push_at    [SLOT_COUNT];
   logic [TIME_W-1:0]  push_gap   [SLOT_COUNT];
   logic [BEAT_W-1:0]  fast_beats [SLOT_COUNT];
   logic [TOTAL_W-1:0] live_total = '0;

   table_evt_t step_events [$];
   table_evt_t pending_events [$];
   plan_row_t  plan [$];
   table_evt_t got_word;
   table_evt_t want_word;
   int         failures = 0;
   int         rsp_hold = 0;
   bit         quiet = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint elapsed(logic [TIME_W-1:0] t_now, logic [TIME_W-1:0] t_then);
      return longint'({16'h0, t_now}) - longint'({16'h0, t_then});
   endfunction

   function automatic table_evt_t make_evt(logic [KIND_W-1:0] kind, logic [ID_W-1:0] slot,
                                           logic [TIME_W-1:0] ptime, logic [WALL_W-1:0] pwall,
                                           logic last);
      table_evt_t e;
      e.kind  = kind;
      e.slot  = slot;
      e.ptime = ptime;
      e.pwall = pwall;
      e.count = live_total;
      e.last  = last;
      return e;
   endfunction

   function automatic table_req_t mk_req(logic [REQ_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] now, logic [WALL_W-1:0] wall);
      table_req_t r;
      r.op   = op;
      r.id   = id;
      r.now  = now;
      r.wall = wall;
      return r;
   endfunction

   // next state of the table and the words one request causes
   task automatic predict_table(input table_req_t r);
      int  i;
      bit  in_range;
      step_events.delete();
      in_range = r.id < SLOT_COUNT;
      case (r.op)
         REQ_TICK: begin
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (!slot_live[i]) continue;
               if (elapsed(r.now, beat_at[i]) > longint'({32'h0, cfg_timeout})) begin
                  step_events.push_back(make_evt(EV_LOGOUT, ID_W'(i), '0, '0, 1'b0));
                  continue;
               end
               if (elapsed(r.now, push_at[i]) > longint'({16'h0, push_gap[i]})) begin
                  push_at[i] = r.now;
                  push_gap[i] = (push_gap[i] > INTERVAL_SAT) ? INTERVAL_MAX
                                                             : push_gap[i] * 48'd10;
                  step_events.push_back(make_evt(EV_PUSH, ID_W'(i), r.now, r.wall, 1'b0));
               end
            end
            step_events.push_back(make_evt(EV_ACK, '0, '0, '0, 1'b1));
            return;
         end
         REQ_ADD: begin
            if (in_range && !slot_live[r.id]) begin
               slot_live[r.id]  = 1'b1;
               beat_at[r.id]    = r.now;
               push_at[r.id]    = r.now;
               push_gap[r.id]   = FIRST_INTERVAL;
               fast_beats[r.id] = '0;
               live_total++;
            end
         end
         REQ_DEL: begin
            if (in_range && slot_live[r.id]) begin
               slot_live[r.id] = 1'b0;
               live_total--;
            end
         end
         default: begin
            if (in_range && slot_live[r.id]) begin
               if (elapsed(r.now, beat_at[r.id]) <= longint'({32'h0, cfg_speedup})) begin
                  if (fast_beats[r.id] < 8'd255) fast_beats[r.id]++;
                  if (fast_beats[r.id] >= cfg_limit) begin
                     step_events.push_back(make_evt(EV_LOGOUT, r.id, '0, '0, 1'b1));
                     return;
                  end
                  beat_at[r.id] = r.now;
               end else begin
                  beat_at[r.id]    = r.now;
                  fast_beats[r.id] = '0;
               end
            end
         end
      endcase
      step_events.push_back(make_evt(EV_ACK, r.id, '0, '0, 1'b1));
   endtask

   task automatic send_word(input table_req_t r, input logic typed, input table_evt_t want);
      req_valid        <= 1'b1;
      req_type         <= r.op;
      req_conn_id      <= r.id;
      req_now_ms       <= r.now;
      req_wall_seconds <= r.wall;
      do @(posedge clock); while (!req_ready);
      predict_table(r);
      if (typed) pending_events.push_back(want);
      else foreach (step_events[j]) pending_events.push_back(step_events[j]);
      if (!quiet && $urandom_range(0, 9) < 4) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic settle_table();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   task automatic set_limits(input logic [CSR_W-1:0] timeout, input logic [CSR_W-1:0] speedup,
                             input logic [BEAT_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      cfg_timeout = timeout;
      csr_index <= CSR_SPEEDUP;
      csr_wdata <= speedup;
      @(posedge clock);
      cfg_speedup = speedup;
      csr_index <= CSR_LIMIT;
      csr_wdata <= {{(CSR_W - BEAT_W){1'b0}}, limit};
      @(posedge clock);
      cfg_limit = limit;
      csr_we <= 1'b0;
   endtask

   task automatic add_plan(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now, input logic [WALL_W-1:0] wall,
                           input logic typed, input logic [KIND_W-1:0] kind,
                           input logic [ID_W-1:0] slot, input logic [TOTAL_W-1:0] count);
      plan_row_t row;
      row.r     = mk_req(op, id, now, wall);
      row.typed = typed;
      row.want  = {kind, slot, {TIME_W{1'b0}}, {WALL_W{1'b0}}, count, 1'b1};
      plan.push_back(row);
   endtask

   // result side: check every accepted word, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = {rsp_event_kind, rsp_event_slot, rsp_push_time_ms, rsp_push_wall_seconds,
                     rsp_active_count, rsp_last_of_run};
         if (pending_events.size() == 0) begin
            failures++;
            $display("%0t: unexpected word: kind %0d slot %0d time %0h wall %0h count %0d last %0d",
                     $time, got_word.kind, got_word.slot, got_word.ptime, got_word.pwall,
                     got_word.count, got_word.last);
         end else begin
            want_word = pending_events.pop_front();
            if (got_word !== want_word) begin
               failures++;
               $display("%0t: mismatch: expected kind %0d slot %0d time %0h wall %0h count %0d last %0d",
                        $time, want_word.kind, want_word.slot, want_word.ptime, want_word.pwall,
                        want_word.count, want_word.last);
               $display("%0t:           actual kind %0d slot %0d time %0h wall %0h count %0d last %0d",
                        $time, got_word.kind, got_word.slot, got_word.ptime, got_word.pwall,
                        got_word.count, got_word.last);
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) rsp_hold = pick_gap();
      end
   end

   initial begin
      #10000000;
      $display("connection_heartbeat_table_tb failed");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0] t;
      int                phase;
      int                r;
      logic [REQ_W-1:0]  op;
      logic [ID_W-1:0]   id;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows on reset limits
      add_plan(REQ_TICK, 6'd0, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_ADD, 6'd63, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd63, 7'd0);
      add_plan(REQ_ADD, 6'd32, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd32, 7'd0);
      add_plan(REQ_DEL, 6'd0, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd7, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd7, 7'd0);
      add_plan(REQ_ADD, 6'd0, 48'd1000, 32'd0, 1'b1, EV_ACK, 6'd0, 7'd1);
      add_plan(REQ_ADD, 6'd31, 48'd1000, 32'd0, 1'b1, EV_ACK, 6'd31, 7'd2);
      add_plan(REQ_ADD, 6'd0, 48'd5000, 32'd0, 1'b1, EV_ACK, 6'd0, 7'd2);
      add_plan(REQ_BEAT, 6'd0, 48'd1500, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd2500, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd3501, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd3600, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd3700, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd3800, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd3900, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd4000, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd0, 48'd100, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_TICK, 6'd0, 48'd11501, 32'hFFFF_FFFF, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_TICK, 6'd0, {TIME_W{1'b1}}, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd31, {TIME_W{1'b1}}, 32'd0, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_TICK, 6'd0, 48'd0, 32'hA5A5_5A5A, 1'b0, EV_ACK, 6'd0, 7'd0);
      add_plan(REQ_BEAT, 6'd63, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd63, 7'd2);
      add_plan(REQ_DEL, 6'd31, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd31, 7'd1);
      add_plan(REQ_DEL, 6'd0, 48'd0, 32'd0, 1'b1, EV_ACK, 6'd0, 7'd0);
      foreach (plan[k]) send_word(plan[k].r, plan[k].typed, plan[k].want);

      // push interval grows until it saturates
      settle_table();
      set_limits({CSR_W{1'b1}}, SPEEDUP_RESET, LIMIT_RESET);
      t = '0;
      send_word(mk_req(REQ_ADD, 6'd3, t, $urandom()), 1'b0, '0);
      while (push_gap[3] != INTERVAL_MAX && t <= INTERVAL_MAX - push_gap[3] - 48'd1) begin
         t = t + push_gap[3] + 48'd1;
         send_word(mk_req(REQ_BEAT, 6'd3, t, $urandom()), 1'b0, '0);
         send_word(mk_req(REQ_TICK, 6'd3, t, $urandom()), 1'b0, '0);
      end
      send_word(mk_req(REQ_TICK, 6'd0, t, $urandom()), 1'b0, '0);
      send_word(mk_req(REQ_DEL, 6'd3, t, $urandom()), 1'b0, '0);

      // fast-beat burst keeps asking for logout past the limit
      settle_table();
      set_limits(TIMEOUT_RESET, SPEEDUP_RESET, LIMIT_RESET);
      t = 48'h8000_0000_0000;
      send_word(mk_req(REQ_ADD, 6'd9, t, $urandom()), 1'b0, '0);
      repeat (12) send_word(mk_req(REQ_BEAT, 6'd9, t, $urandom()), 1'b0, '0);
      send_word(mk_req(REQ_DEL, 6'd9, t, $urandom()), 1'b0, '0);

      // random traffic under several limit settings
      t = TIME_W'($urandom_range(0, 100000));
      for (phase = 0; phase < 4; phase++) begin
         settle_table();
         case (phase)
            0: set_limits(TIMEOUT_RESET, SPEEDUP_RESET, LIMIT_RESET);
            1: set_limits('0, '0, '0);
            2: set_limits({CSR_W{1'b1}}, {CSR_W{1'b1}}, {BEAT_W{1'b1}});
            default: set_limits($urandom_range(500, 60000), $urandom_range(0, 3000),
                                BEAT_W'($urandom_range(1, 12)));
         endcase
         repeat (48) begin
            r = $urandom_range(0, 99);
            if (r < 70) t = t + TIME_W'($urandom_range(0, 1200));
            else if (r < 85) t = t + TIME_W'($urandom_range(1000, 40000));
            else if (r < 92) begin
               r = $urandom_range(0, 5000);
               t = (t > TIME_W'(r)) ? t - TIME_W'(r) : '0;
            end else if (r < 97) t = t + TIME_W'({$urandom_range(0, 255), $urandom()});
            else t = TIME_W'({$urandom(), $urandom()});
            r = $urandom_range(0, 99);
            if (r < 25) op = REQ_ADD;
            else if (r < 35) op = REQ_DEL;
            else if (r < 75) op = REQ_BEAT;
            else op = REQ_TICK;
            r = $urandom_range(0, 99);
            if (r < 60) id = ID_W'($urandom_range(0, 7));
            else if (r < 85) id = ID_W'($urandom_range(0, SLOT_COUNT - 1));
            else id = ID_W'($urandom_range(0, 63));
            if ($urandom_range(0, 24) == 0) settle_table();
            send_word(mk_req(op, id, t, $urandom()), 1'b0, '0);
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
         end
      end

      settle_table();
      repeat (100) @(posedge clock);
      if (failures == 0) $display("connection_heartbeat_table_tb passed");
      else $display("connection_heartbeat_table_tb failed");
      $finish;
   end
endmodule
